// File: src/hnm_pkg.sv
// hnm_pkg: shared types and constants of the height field normal map block
// used by hnm_ctrl, hnm_dp and heightfield_normal_map_top; no dependencies
package hnm_pkg;

    localparam int LINE_LEN = 1024;
    localparam int COL_W    = $clog2(LINE_LEN);
    localparam int SX_W     = 11;
    localparam int SZ_W     = 16;
    localparam int CELL_W   = 16;
    localparam int H_W      = 16;
    localparam int Q_W      = 15;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        REG_SAMPLES_X   = 2'd0,
        REG_SAMPLES_Z   = 2'd1,
        REG_CELL_SIZE_X = 2'd2,
        REG_CELL_SIZE_Z = 2'd3
    } hnm_reg_t;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2
    } hnm_comp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_MULX,
        ST_MULY,
        ST_MULZ,
        ST_NORM,
        ST_SQX,
        ST_SQY,
        ST_SQZ,
        ST_SUM,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_STORE,
        ST_OUT
    } hnm_state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_READ,
        OP_COMMIT,
        OP_MULX,
        OP_MULY,
        OP_MULZ,
        OP_SHIFT,
        OP_SQX,
        OP_SQY,
        OP_SQZ,
        OP_SUM,
        OP_DIV_INIT,
        OP_DIV,
        OP_SQRT_INIT,
        OP_SQRT,
        OP_STORE,
        OP_LOAD
    } hnm_op_t;

    typedef struct packed {
        logic      take;
        hnm_op_t   op;
        hnm_comp_t comp;
    } hnm_cmd_t;

    typedef struct packed {
        logic emit;
        logic norm_ok;
        logic div_last;
        logic sqrt_last;
        logic out_free;
    } hnm_stat_t;

    typedef struct packed {
        logic [SX_W-1:0]   samples_x;
        logic [SZ_W-1:0]   samples_z;
        logic [CELL_W-1:0] cell_size_x;
        logic [CELL_W-1:0] cell_size_z;
    } hnm_cfg_t;

endpackage

// File: src/heightfield_normal_map_top.sv
// heightfield_normal_map_top: top level with the register port
// depends on hnm_pkg, hnm_ctrl and hnm_dp
//
// Height samples (mode 0) arrive in raster order and each one from the
// second row on produces the unit normal of the sample one row above it;
// after the last sample of a frame, drain items (mode 1) produce the last
// row, the final normal carrying last_of_frame. Normals are Q1.14, rounded
// to nearest. One item is processed at a time. An item that produces a
// normal first shifts the scaled vector right by 0 to 17 bits until it
// fits in 16 bits, then runs the shared restoring divider and bit-serial
// square root once per component. The finished normal waits in an
// output register, so the next item is taken while it is still stalled.
// Registers sit at byte addresses 0 (samples_x), 4 (samples_z),
// 8 (cell_size_x) and 12 (cell_size_z); write them only between items.
module heightfield_normal_map_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hnm_pkg::ADDR_W-1:0]    paddr,
    input  logic [hnm_pkg::DATA_W-1:0]    pwdata,
    output logic [hnm_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [hnm_pkg::H_W-1:0] height,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [hnm_pkg::H_W-1:0] normal_x,
    output logic [hnm_pkg::Q_W-1:0]       normal_y,
    output logic signed [hnm_pkg::H_W-1:0] normal_z,
    output logic                          last_of_frame
);
    import hnm_pkg::*;

    hnm_cfg_t  cfg_reg;
    hnm_cmd_t  cmd;
    hnm_stat_t stat;
    hnm_reg_t  reg_sel;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = hnm_reg_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // configuration registers, reset to a 1024 x 1024 grid of unit cells
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.samples_x   <= SX_W'(1024);
            cfg_reg.samples_z   <= SZ_W'(1024);
            cfg_reg.cell_size_x <= CELL_W'(256);
            cfg_reg.cell_size_z <= CELL_W'(256);
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SAMPLES_X:   cfg_reg.samples_x   <= pwdata[SX_W-1:0];
                REG_SAMPLES_Z:   cfg_reg.samples_z   <= pwdata[SZ_W-1:0];
                REG_CELL_SIZE_X: cfg_reg.cell_size_x <= pwdata[CELL_W-1:0];
                REG_CELL_SIZE_Z: cfg_reg.cell_size_z <= pwdata[CELL_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_sel)
            REG_SAMPLES_X:   prdata = DATA_W'(cfg_reg.samples_x);
            REG_SAMPLES_Z:   prdata = DATA_W'(cfg_reg.samples_z);
            REG_CELL_SIZE_X: prdata = DATA_W'(cfg_reg.cell_size_x);
            REG_CELL_SIZE_Z: prdata = DATA_W'(cfg_reg.cell_size_z);
            default:         prdata = '0;
        endcase
    end

    // sequencer
    hnm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // line stores and arithmetic
    hnm_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .mode          (mode),
        .height        (height),
        .out_stall     (out_stall),
        .stat          (stat),
        .out_valid     (out_valid),
        .normal_x      (normal_x),
        .normal_y      (normal_y),
        .normal_z      (normal_z),
        .last_of_frame (last_of_frame)
    );

endmodule

// File: src/hnm_ctrl.sv
// hnm_ctrl: sequencer of the normal map datapath, one item at a time
// depends on hnm_pkg
module hnm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  hnm_pkg::hnm_stat_t stat,
    output logic             in_stall,
    output hnm_pkg::hnm_cmd_t  cmd
);
    import hnm_pkg::*;

    hnm_state_t state_reg, state_next;
    hnm_comp_t  comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            comp_reg  <= COMP_X;
        end
        else
        begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_READ;
            ST_READ:      state_next = ST_EVAL;
            ST_EVAL:      state_next = stat.emit ? ST_MULX : ST_IDLE;
            ST_MULX:      state_next = ST_MULY;
            ST_MULY:      state_next = ST_MULZ;
            ST_MULZ:      state_next = ST_NORM;
            ST_NORM:      if (stat.norm_ok) state_next = ST_SQX;
            ST_SQX:       state_next = ST_SQY;
            ST_SQY:       state_next = ST_SQZ;
            ST_SQZ:       state_next = ST_SUM;
            ST_SUM:
            begin
                state_next = ST_DIV_INIT;
                comp_next  = COMP_X;
            end
            ST_DIV_INIT:  state_next = ST_DIV;
            ST_DIV:       if (stat.div_last) state_next = ST_SQRT_INIT;
            ST_SQRT_INIT: state_next = ST_SQRT;
            ST_SQRT:      if (stat.sqrt_last) state_next = ST_STORE;
            ST_STORE:
            begin
                unique case (comp_reg)
                    COMP_X:  comp_next = COMP_Y;
                    COMP_Y:  comp_next = COMP_Z;
                    default: comp_next = COMP_X;
                endcase
                state_next = (comp_reg == COMP_Z) ? ST_OUT : ST_DIV_INIT;
            end
            ST_OUT:       if (stat.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        cmd.take = (state_reg == ST_IDLE) && in_valid;
        cmd.comp = comp_reg;
        cmd.op   = OP_NONE;
        unique case (state_reg)
            ST_IDLE:      cmd.op = OP_NONE;
            ST_READ:      cmd.op = OP_READ;
            ST_EVAL:      cmd.op = OP_COMMIT;
            ST_MULX:      cmd.op = OP_MULX;
            ST_MULY:      cmd.op = OP_MULY;
            ST_MULZ:      cmd.op = OP_MULZ;
            ST_NORM:      cmd.op = stat.norm_ok ? OP_NONE : OP_SHIFT;
            ST_SQX:       cmd.op = OP_SQX;
            ST_SQY:       cmd.op = OP_SQY;
            ST_SQZ:       cmd.op = OP_SQZ;
            ST_SUM:       cmd.op = OP_SUM;
            ST_DIV_INIT:  cmd.op = OP_DIV_INIT;
            ST_DIV:       cmd.op = OP_DIV;
            ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
            ST_SQRT:      cmd.op = OP_SQRT;
            ST_STORE:     cmd.op = OP_STORE;
            ST_OUT:       cmd.op = stat.out_free ? OP_LOAD : OP_NONE;
            default:      cmd.op = OP_NONE;
        endcase
    end

    a_eval_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL && !stat.emit) |=> (state_reg == ST_IDLE))
        else $error("item without a normal did not return to idle");

    a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !stat.out_free) |=> (state_reg == ST_OUT))
        else $error("result dropped while output register busy");

    a_comp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> (comp_reg == COMP_X || comp_reg == COMP_Y
                                     || comp_reg == COMP_Z))
        else $error("component index out of range");

endmodule

// File: src/hnm_dp.sv
// hnm_dp: line stores, neighbor selection, scaling, divider and square root
// depends on hnm_pkg; driven by hnm_ctrl
module hnm_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hnm_pkg::hnm_cfg_t             cfg,
    input  hnm_pkg::hnm_cmd_t             cmd,
    input  logic                          mode,
    input  logic signed [hnm_pkg::H_W-1:0] height,
    input  logic                          out_stall,
    output hnm_pkg::hnm_stat_t            stat,
    output logic                          out_valid,
    output logic signed [hnm_pkg::H_W-1:0] normal_x,
    output logic [hnm_pkg::Q_W-1:0]       normal_y,
    output logic signed [hnm_pkg::H_W-1:0] normal_z,
    output logic                          last_of_frame
);
    import hnm_pkg::*;

    // line stores
    logic signed [H_W-1:0] above_mem [LINE_LEN];
    logic signed [H_W-1:0] two_mem   [LINE_LEN];

    // position state
    logic [COL_W-1:0] col_reg;
    logic [SZ_W-1:0]  row_reg;
    logic             draining_reg;
    logic signed [H_W-1:0] left_reg;

    // item and read data
    logic             mode_reg;
    logic signed [H_W-1:0] height_reg;
    logic signed [H_W-1:0] c_rd_reg, r_rd_reg, d_rd_reg;

    // vector math
    logic [H_W-1:0]  absdx_reg, absdz_reg;
    logic            sdx_reg, sdz_reg, last_reg;
    logic [32:0]     mx_reg, my_reg, mz_reg;
    logic [31:0]     a2x_reg, a2y_reg, a2z_reg;
    logic [33:0]     s_reg;
    logic [34:0]     rem_reg;
    logic [30:0]     quo_reg;
    logic [30:0]     op_reg, res_reg, one_reg;
    logic [4:0]      cnt_reg;
    logic [Q_W-1:0]  qx_reg, qy_reg, qz_reg;

    // output register
    logic            out_valid_reg;
    logic signed [H_W-1:0] nx_reg, nz_reg;
    logic [Q_W-1:0]  ny_reg;
    logic            last_out_reg;

    // effective configuration
    logic [SX_W-1:0]   sx_eff;
    logic [SZ_W-1:0]   sz_eff;
    logic [CELL_W-1:0] cx_eff, cz_eff;

    always_comb
    begin
        if (cfg.samples_x < SX_W'(2))
            sx_eff = SX_W'(2);
        else if (cfg.samples_x > SX_W'(LINE_LEN))
            sx_eff = SX_W'(LINE_LEN);
        else
            sx_eff = cfg.samples_x;
        sz_eff = (cfg.samples_z < SZ_W'(2)) ? SZ_W'(2) : cfg.samples_z;
        cx_eff = (cfg.cell_size_x == '0) ? CELL_W'(1) : cfg.cell_size_x;
        cz_eff = (cfg.cell_size_z == '0) ? CELL_W'(1) : cfg.cell_size_z;
    end

    // neighbor selection
    logic [SX_W-1:0]  col_inc;
    logic             r_in;
    logic [COL_W-1:0] ri;
    logic [SZ_W:0]    row_inc;
    logic signed [H_W-1:0] c_v, l_v, r_v, d_v, u_v;
    logic signed [H_W:0]   dx, dz;
    logic [H_W:0]     absdx_w, absdz_w;
    logic             is_drain, do_sample, do_drain, last_col;

    always_comb
    begin
        col_inc   = SX_W'(col_reg) + SX_W'(1);
        r_in      = (col_inc < sx_eff);
        ri        = r_in ? col_inc[COL_W-1:0] : COL_W'(sx_eff - SX_W'(1));
        row_inc   = {1'b0, row_reg} + (SZ_W+1)'(1);
        is_drain  = mode_reg;
        do_sample = !is_drain && !draining_reg;
        do_drain  = is_drain && draining_reg;
        last_col  = !r_in;
        c_v = c_rd_reg;
        l_v = (col_reg != '0) ? left_reg : c_v;
        r_v = r_in ? r_rd_reg : c_v;
        if (is_drain)
        begin
            d_v = (row_reg != '0) ? d_rd_reg : c_v;
            u_v = c_v;
        end
        else
        begin
            d_v = (row_reg > SZ_W'(1)) ? d_rd_reg : c_v;
            u_v = height_reg;
        end
        dx = {l_v[H_W-1], l_v} - {r_v[H_W-1], r_v};
        dz = {d_v[H_W-1], d_v} - {u_v[H_W-1], u_v};
        absdx_w = dx[H_W] ? (H_W+1)'(-dx) : (H_W+1)'(dx);
        absdz_w = dz[H_W] ? (H_W+1)'(-dz) : (H_W+1)'(dz);
    end

    // shared 16x16 multiplier
    logic [15:0] mul_a, mul_b;
    logic [31:0] prod;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MULX: begin mul_a = absdx_reg;     mul_b = cz_eff;        end
            OP_MULY: begin mul_a = cx_eff;        mul_b = cz_eff;        end
            OP_MULZ: begin mul_a = absdz_reg;     mul_b = cx_eff;        end
            OP_SQX:  begin mul_a = mx_reg[15:0];  mul_b = mx_reg[15:0];  end
            OP_SQY:  begin mul_a = my_reg[15:0];  mul_b = my_reg[15:0];  end
            OP_SQZ:  begin mul_a = mz_reg[15:0];  mul_b = mz_reg[15:0];  end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
        prod = mul_a * mul_b;
    end

    // divider and square root steps
    logic [31:0] a2_sel;
    logic [35:0] rem_diff;
    logic        rem_ge;
    logic [31:0] sq_sum;
    logic        sq_ge;
    logic [Q_W-1:0] q_new;

    always_comb
    begin
        case (cmd.comp)
            COMP_X:  a2_sel = a2x_reg;
            COMP_Y:  a2_sel = a2y_reg;
            default: a2_sel = a2z_reg;
        endcase
        rem_diff = {1'b0, rem_reg} - {2'b0, s_reg};
        rem_ge   = !rem_diff[35];
        sq_sum   = {1'b0, res_reg} + {1'b0, one_reg};
        sq_ge    = ({1'b0, op_reg} >= sq_sum);
        q_new    = Q_W'((17'(res_reg[15:0]) + 17'(1)) >> 1);
    end

    assign stat.emit      = (!is_drain && !draining_reg && row_reg != '0) || do_drain;
    assign stat.norm_ok   = (mx_reg[32:16] == '0) && (my_reg[32:16] == '0)
                            && (mz_reg[32:16] == '0);
    assign stat.div_last  = (cnt_reg == '0);
    assign stat.sqrt_last = (cnt_reg == '0);
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // line stores
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_READ)
        begin
            c_rd_reg <= above_mem[col_reg];
            r_rd_reg <= above_mem[ri];
            d_rd_reg <= two_mem[col_reg];
        end
        if (cmd.op == OP_COMMIT && do_sample)
        begin
            above_mem[col_reg] <= height_reg;
            if (row_reg != '0)
                two_mem[col_reg] <= c_v;
        end
    end

    // position control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            draining_reg  <= 1'b0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_COMMIT && do_sample)
            begin
                if (row_reg != '0)
                    left_reg <= c_v;
                if (last_col)
                begin
                    col_reg <= '0;
                    if (row_inc >= {1'b0, sz_eff})
                    begin
                        draining_reg <= 1'b1;
                        if (row_reg == '0)
                            row_reg <= SZ_W'(1);
                    end
                    else
                    begin
                        row_reg <= row_inc[SZ_W-1:0];
                    end
                end
                else
                begin
                    col_reg <= col_inc[COL_W-1:0];
                end
            end
            else if (cmd.op == OP_COMMIT && do_drain)
            begin
                left_reg <= c_v;
                if (last_col)
                begin
                    col_reg      <= '0;
                    row_reg      <= '0;
                    draining_reg <= 1'b0;
                end
                else
                begin
                    col_reg <= col_inc[COL_W-1:0];
                end
            end
            if (cmd.op == OP_LOAD)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            mode_reg   <= mode;
            height_reg <= height;
        end
        case (cmd.op)
            OP_COMMIT:
            begin
                absdx_reg <= absdx_w[H_W-1:0];
                absdz_reg <= absdz_w[H_W-1:0];
                sdx_reg   <= dx[H_W];
                sdz_reg   <= dz[H_W];
                last_reg  <= do_drain && last_col;
            end
            OP_MULX: mx_reg <= {1'b0, prod};
            OP_MULY: my_reg <= {prod, 1'b0};
            OP_MULZ: mz_reg <= {1'b0, prod};
            OP_SHIFT:
            begin
                mx_reg <= mx_reg >> 1;
                my_reg <= my_reg >> 1;
                mz_reg <= mz_reg >> 1;
            end
            OP_SQX: a2x_reg <= prod;
            OP_SQY: a2y_reg <= prod;
            OP_SQZ: a2z_reg <= prod;
            OP_SUM: s_reg <= 34'(a2x_reg) + 34'(a2y_reg) + 34'(a2z_reg);
            OP_DIV_INIT:
            begin
                rem_reg <= 35'(a2_sel);
                quo_reg <= '0;
                cnt_reg <= 5'd30;
            end
            OP_DIV:
            begin
                quo_reg <= {quo_reg[29:0], rem_ge};
                rem_reg <= rem_ge ? {rem_diff[33:0], 1'b0} : {rem_reg[33:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            OP_SQRT_INIT:
            begin
                op_reg  <= quo_reg;
                res_reg <= '0;
                one_reg <= 31'(1) << 30;
                cnt_reg <= 5'd15;
            end
            OP_SQRT:
            begin
                if (sq_ge)
                begin
                    op_reg  <= op_reg - sq_sum[30:0];
                    res_reg <= (res_reg >> 1) + one_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                one_reg <= one_reg >> 2;
                cnt_reg <= cnt_reg - 5'd1;
            end
            OP_STORE:
            begin
                case (cmd.comp)
                    COMP_X:  qx_reg <= q_new;
                    COMP_Y:  qy_reg <= q_new;
                    default: qz_reg <= q_new;
                endcase
            end
            OP_LOAD:
            begin
                nx_reg       <= sdx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
                ny_reg       <= qy_reg;
                nz_reg       <= sdz_reg ? -$signed({1'b0, qz_reg}) : $signed({1'b0, qz_reg});
                last_out_reg <= last_reg;
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign normal_x      = nx_reg;
    assign normal_y      = ny_reg;
    assign normal_z      = nz_reg;
    assign last_of_frame = last_out_reg;

    a_drain_row: assert property (@(posedge clk) disable iff (!rst_n)
        draining_reg |-> (row_reg != '0))
        else $error("draining with row position zero");

    a_shift_needed: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SHIFT) |-> !stat.norm_ok)
        else $error("scaling shift applied to an already narrow vector");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_STORE) |-> (res_reg <= 31'd32768))
        else $error("square root beyond unit range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> stat.out_free)
        else $error("output register overwritten");

endmodule

// File: sim/hnm_checker.sv
// hnm_checker: watches the item and register ports of the normal map block,
// predicts each normal and compares it; depends on hnm_pkg only
`timescale 1ns / 100ps

module hnm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [hnm_pkg::ADDR_W-1:0]     paddr,
    input  logic [hnm_pkg::DATA_W-1:0]     pwdata,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           mode,
    input  logic signed [hnm_pkg::H_W-1:0] height,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [hnm_pkg::H_W-1:0] normal_x,
    input  logic [hnm_pkg::Q_W-1:0]        normal_y,
    input  logic signed [hnm_pkg::H_W-1:0] normal_z,
    input  logic                           last_of_frame,
    output int                             errors,
    output int                             pending
);
    import hnm_pkg::*;

    typedef struct {
        logic signed [H_W-1:0] nx;
        logic [Q_W-1:0]        ny;
        logic signed [H_W-1:0] nz;
        logic                  last;
    } normal_t;

    normal_t normals_due[$];

    logic signed [H_W-1:0] line_above [LINE_LEN];
    logic signed [H_W-1:0] line_two_above [LINE_LEN];
    int unsigned col_pos, row_pos;
    logic        in_drain;
    int          left_h;
    hnm_cfg_t    cfg;

    // largest q with (2q-1)^2 * s <= a^2 * 2^30, i.e. rounded a*2^14/sqrt(s)
    function automatic int unsigned unit_mag(logic [63:0] a, logic [63:0] s);
        logic [127:0] lo, hi, mid, t;
        lo = 0;
        hi = 16384;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * s <= ((a * a) << 30)) lo = mid;
            else hi = mid - 1;
        end
        return int'(lo);
    endfunction

    function automatic normal_t surface_normal(int l, int r, int d, int u, logic last);
        normal_t     n;
        longint      dx, dz;
        logic [63:0] cx, cz, mx, my, mz, m, s;
        int unsigned qx, qy, qz;
        cx = (cfg.cell_size_x == 0) ? 64'd1 : 64'(cfg.cell_size_x);
        cz = (cfg.cell_size_z == 0) ? 64'd1 : 64'(cfg.cell_size_z);
        dx = longint'(l) - longint'(r);
        dz = longint'(d) - longint'(u);
        mx = 64'(dx < 0 ? -dx : dx) * cz;
        my = 2 * cx * cz;
        mz = 64'(dz < 0 ? -dz : dz) * cx;
        m = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        // bring the largest component under 16 bits
        while (m >= 65536) begin
            m = m >> 1;
            mx = mx >> 1;
            my = my >> 1;
            mz = mz >> 1;
        end
        s = mx * mx + my * my + mz * mz;
        qx = unit_mag(mx, s);
        qy = unit_mag(my, s);
        qz = unit_mag(mz, s);
        n.nx = (dx < 0) ? -16'(qx) : 16'(qx);
        n.ny = 15'(qy);
        n.nz = (dz < 0) ? -16'(qz) : 16'(qz);
        n.last = last;
        return n;
    endfunction

    task automatic predict_item(logic m, logic signed [H_W-1:0] h);
        int unsigned sx, sz, col;
        int          c, l, r, d;
        logic        last;
        sx = cfg.samples_x;
        if (sx < 2) sx = 2;
        if (sx > LINE_LEN) sx = LINE_LEN;
        sz = (cfg.samples_z < 2) ? 2 : cfg.samples_z;
        col = col_pos % LINE_LEN;
        c = line_above[col];
        l = (col > 0) ? left_h : c;
        r = (col + 1 < sx) ? int'(line_above[col + 1]) : c;
        d = (row_pos > 1) ? int'(line_two_above[col]) : c;
        if (m == 1'b0) begin
            // samples are dropped while the last row drains
            if (in_drain) return;
            if (row_pos != 0) begin
                normals_due.push_back(surface_normal(l, r, d, int'(h), 1'b0));
                left_h = c;
                line_two_above[col] = c;
            end
            line_above[col] = h;
            col++;
            if (col >= sx) begin
                col = 0;
                if (row_pos + 1 >= sz) begin
                    in_drain = 1'b1;
                    if (row_pos == 0) row_pos = 1;
                end else begin
                    row_pos++;
                end
            end
            col_pos = col;
        end else begin
            if (!in_drain) return;
            d = (row_pos > 0) ? int'(line_two_above[col]) : c;
            last = (col + 1 >= sx);
            normals_due.push_back(surface_normal(l, r, d, c, last));
            left_h = c;
            if (last) begin
                col_pos = 0;
                row_pos = 0;
                in_drain = 1'b0;
            end else begin
                col_pos = col + 1;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        normal_t want;
        if (!rst_n) begin
            col_pos = 0;
            row_pos = 0;
            in_drain = 1'b0;
            left_h = 0;
            cfg.samples_x = 11'd1024;
            cfg.samples_z = 16'd1024;
            cfg.cell_size_x = 16'd256;
            cfg.cell_size_z = 16'd256;
            errors = 0;
            normals_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (hnm_reg_t'(paddr[3:2]))
                    REG_SAMPLES_X:   cfg.samples_x = pwdata[SX_W-1:0];
                    REG_SAMPLES_Z:   cfg.samples_z = pwdata[SZ_W-1:0];
                    REG_CELL_SIZE_X: cfg.cell_size_x = pwdata[CELL_W-1:0];
                    REG_CELL_SIZE_Z: cfg.cell_size_z = pwdata[CELL_W-1:0];
                endcase
            end
            if (out_valid && !out_stall) begin
                if (normals_due.size() == 0) begin
                    $display("%0t: unexpected normal %0d %0d %0d last %0d", $time,
                             normal_x, normal_y, normal_z, last_of_frame);
                    errors++;
                end else begin
                    want = normals_due.pop_front();
                    if (normal_x !== want.nx || normal_y !== want.ny ||
                        normal_z !== want.nz || last_of_frame !== want.last) begin
                        $display("%0t: normal mismatch expected %0d %0d %0d last %0d, got %0d %0d %0d last %0d",
                                 $time, want.nx, want.ny, want.nz, want.last,
                                 normal_x, normal_y, normal_z, last_of_frame);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall) predict_item(mode, height);
        end
        pending = normals_due.size();
    end

endmodule

// File: sim/heightfield_normal_map_top_tb.sv
// heightfield_normal_map_top_tb: stimulus and verdict for the normal map block
// depends on hnm_pkg, heightfield_normal_map_top and hnm_checker
`timescale 1ns / 100ps

module heightfield_normal_map_top_tb;
    import hnm_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  psel, penable, pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  in_valid, in_stall, mode;
    logic signed [H_W-1:0] height;
    logic                  out_valid, out_stall;
    logic signed [H_W-1:0] normal_x, normal_z;
    logic [Q_W-1:0]        normal_y;
    logic                  last_of_frame;
    int                    errors, pending;

    // idle chances in percent, changed per phase
    int send_pct = 0;
    int recv_pct = 0;
    // long receiver hold-offs asked for by the stimulus
    int hold_asked = 0;
    int items_sent = 0;

    heightfield_normal_map_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .height(height),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .last_of_frame(last_of_frame)
    );

    hnm_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .height(height),
        .out_valid(out_valid), .out_stall(out_stall),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .last_of_frame(last_of_frame),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #100000000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, plus a long counted hold-off when asked
    initial
    begin
        int served;
        int hold_left;
        served = 0;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && served != hold_asked)
            begin
                served = hold_asked;
                hold_left = 1500;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_pct);
        end
    end

    // one register write: setup cycle, access cycle, then back to idle
    task automatic reg_write(hnm_reg_t idx, int unsigned value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // new settings only once the block has drained all normals and gone quiet
    task automatic set_grid(int unsigned sx, int unsigned sz, int unsigned cx, int unsigned cz);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // let a no-result item still in flight finish, with some margin
        repeat (10) @(posedge clk);
        reg_write(REG_SAMPLES_X, sx);
        reg_write(REG_SAMPLES_Z, sz);
        reg_write(REG_CELL_SIZE_X, cx);
        reg_write(REG_CELL_SIZE_Z, cz);
    endtask

    // offer one item and hold it until it is taken
    task automatic send_item(logic m, logic signed [H_W-1:0] h);
        logic st;
        while ($urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        height   <= h;
        do
        begin
            @(negedge clk);
            st = in_stall;
            @(posedge clk);
        end
        while (st);
        items_sent++;
    endtask

    function automatic logic signed [H_W-1:0] pick_height();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'($urandom_range(255)) - 16'sd128;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_cell();
        case ($urandom_range(5))
            0: return 0;
            1: return 65535;
            2: return 1;
            3: return 256;
            default: return $urandom_range(65535);
        endcase
    endfunction

    // a whole frame of samples and its drain row, with optional ignored noise
    task automatic run_frame(int unsigned sx, int unsigned sz, bit noise, int hold_at);
        int n;
        n = 0;
        if (noise) send_item(1'b1, pick_height());   // drain tick while idle
        for (int r = 0; r < sz; r++)
            for (int c = 0; c < sx; c++)
            begin
                if (n == hold_at) hold_asked++;
                send_item(1'b0, pick_height());
                n++;
            end
        for (int c = 0; c < sx; c++)
        begin
            // samples during the drain are dropped by the block
            if (noise && $urandom_range(9) == 0) send_item(1'b0, pick_height());
            send_item(1'b1, pick_height());
        end
    endtask

    initial
    begin
        int unsigned sx, sz;
        int          frame_no;
        int          base;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        mode     = 1'b0;
        height   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: smallest grid with height extremes and both ignored cases
        set_grid(2, 2, 256, 256);
        send_item(1'b1, 16'sh0000);
        send_item(1'b0, 16'sh8000);
        send_item(1'b0, 16'sh7fff);
        send_item(1'b0, 16'sh7fff);
        send_item(1'b0, 16'sh8000);
        send_item(1'b0, 16'sh1234);
        send_item(1'b1, 16'sh7fff);
        send_item(1'b1, 16'sh8000);
        // register values below the floor clamp up
        set_grid(0, 0, 0, 0);
        send_item(1'b0, 16'sh7fff);
        send_item(1'b0, 16'sh8000);
        send_item(1'b0, 16'sh8000);
        send_item(1'b0, 16'sh7fff);
        send_item(1'b1, 16'sh0000);
        send_item(1'b1, 16'sh0000);
        // largest cell sizes, one row count below the floor
        set_grid(3, 1, 65535, 65535);
        run_frame(3, 2, 1'b1, -1);

        // random frames, idling mode rotating per frame
        base = items_sent;
        frame_no = 0;
        while (items_sent - base < 1200)
        begin
            case (frame_no % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 50; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 50; end
                default: begin send_pct = 28; recv_pct = 28; end
            endcase
            sx = ($urandom_range(4) == 0) ? $urandom_range(17, 40) : $urandom_range(2, 8);
            sz = $urandom_range(2, 6);
            set_grid(sx, sz, pick_cell(), pick_cell());
            // one frame sees the long hold-off so the block backs up
            run_frame(sx, sz, $urandom_range(3) == 0, (frame_no == 1) ? sx + 1 : -1);
            frame_no++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
